@@ hw/rtl/bfsp_pkg.sv @@
package bfsp_pkg;

    localparam int FIFO_DEPTH = 8192;
    localparam int IDX_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = IDX_W + 1;

    localparam int BYTE_W     = 8;
    localparam int SAMPLE_W   = 16;
    localparam int TAKEN_W    = 2;
    localparam int QUEUED_W   = 13;

    localparam int CQ_DEPTH   = 2;
    localparam int CQ_PTR_W   = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W   = $clog2(CQ_DEPTH + 1);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;

    // One decoded item as it travels from the front to the back.
    typedef struct packed {
        logic              is_pop;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LO   = 3'b010,
        ST_HI   = 3'b100
    } t_state;

    function automatic t_idx next_slot(t_idx i);
        next_slot = (i == IDX_W'(FIFO_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [QUEUED_W-1:0] queued_count(t_idx wr, t_idx rd);
        logic [CNT_W-1:0] diff;
        diff = {1'b0, wr} - {1'b0, rd};
        if (wr < rd) begin
            diff = diff + CNT_W'(FIFO_DEPTH);
        end
        queued_count = QUEUED_W'(diff);
    endfunction

endpackage

@@ hw/rtl/bfsp_in_if.sv @@
interface bfsp_in_if import bfsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink (input valid, input command, input data_byte, output ready);
endinterface

@@ hw/rtl/bfsp_out_if.sv @@
interface bfsp_out_if import bfsp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       write_accepted;
    logic signed [SAMPLE_W-1:0] sample;
    logic [TAKEN_W-1:0]         bytes_taken;
    logic [QUEUED_W-1:0]        bytes_queued;

    modport source (output valid, output write_accepted, output sample,
                    output bytes_taken, output bytes_queued, input ready);
    modport sink (input valid, input write_accepted, input sample,
                  input bytes_taken, input bytes_queued, output ready);
endinterface

@@ hw/rtl/bfsp_ram.sv @@
module bfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bfsp_front.sv @@
module bfsp_front import bfsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfsp_in_if.sink    i_in,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_ready
);

    t_cmd                r_q [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wp;
    logic [CQ_PTR_W-1:0] r_rp;
    logic [CQ_CNT_W-1:0] r_cnt;
    t_cmd                w_dec;
    logic                w_push;
    logic                w_pop;

    always_comb begin
        w_dec.is_pop = (i_in.command == CMD_POP);
        w_dec.data   = i_in.data_byte;
    end

    assign i_in.ready  = (r_cnt != CQ_CNT_W'(CQ_DEPTH));
    assign w_push      = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/bfsp_back.sv @@
module bfsp_back import bfsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_ready,
    bfsp_out_if.source o_out
);

    t_state                     r_state, n_state;
    t_idx                       r_wr, n_wr;
    t_idx                       r_rd, n_rd;
    logic [BYTE_W-1:0]          r_lo, n_lo;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_acc, n_out_acc;
    logic [SAMPLE_W-1:0]        r_out_sample, n_out_sample;
    logic [TAKEN_W-1:0]         r_out_taken, n_out_taken;
    logic [QUEUED_W-1:0]        r_out_queued, n_out_queued;
    logic                       w_load;
    logic                       w_we;
    logic [BYTE_W-1:0]          w_rdata;
    logic                       w_out_free;

    // The read port always points at the head, so a byte read issued in one
    // cycle is on w_rdata in the next.
    bfsp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wr),
        .i_wdata (i_cmd.data),
        .i_raddr (r_rd),
        .o_rdata (w_rdata)
    );

    assign w_out_free  = !r_out_valid || o_out.ready;
    assign o_cmd_ready = (r_state == ST_IDLE) && w_out_free;

    always_comb begin
        n_state      = r_state;
        n_wr         = r_wr;
        n_rd         = r_rd;
        n_lo         = r_lo;
        w_we         = 1'b0;
        w_load       = 1'b0;
        n_out_acc    = 1'b0;
        n_out_sample = '0;
        n_out_taken  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    if (!i_cmd.is_pop) begin
                        w_load = 1'b1;
                        if (next_slot(r_wr) != r_rd) begin
                            w_we      = 1'b1;
                            n_wr      = next_slot(r_wr);
                            n_out_acc = 1'b1;
                        end
                    end else if (r_rd == r_wr) begin
                        w_load = 1'b1;
                    end else begin
                        n_rd    = next_slot(r_rd);
                        n_state = ST_LO;
                    end
                end
            end
            ST_LO: begin
                n_lo = w_rdata;
                if (r_rd != r_wr) begin
                    n_rd    = next_slot(r_rd);
                    n_state = ST_HI;
                end else begin
                    w_load       = 1'b1;
                    n_out_sample = {{(SAMPLE_W - BYTE_W){1'b0}}, w_rdata};
                    n_out_taken  = TAKEN_W'(1);
                    n_state      = ST_IDLE;
                end
            end
            ST_HI: begin
                w_load       = 1'b1;
                n_out_sample = {w_rdata, r_lo};
                n_out_taken  = TAKEN_W'(2);
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_queued = queued_count(n_wr, n_rd);
        n_out_valid  = w_load || (r_out_valid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr        <= '0;
            r_rd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        if (w_load) begin
            r_out_acc    <= n_out_acc;
            r_out_sample <= n_out_sample;
            r_out_taken  <= n_out_taken;
            r_out_queued <= n_out_queued;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.write_accepted = r_out_acc;
    assign o_out.sample         = r_out_sample;
    assign o_out.bytes_taken    = r_out_taken;
    assign o_out.bytes_queued   = r_out_queued;

    // A pop in flight owns the result register, which was emptied when it began.
    a_pop_owns_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_out_valid)
        else $error("result register busy while a pop is in flight");

    a_taken_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_taken != TAKEN_W'(3)))
        else $error("bytes_taken out of range");

    a_push_takes_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_acc) |-> (r_out_taken == '0 && r_out_sample == '0))
        else $error("push result carries sample bytes");

    a_write_only_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (next_slot(r_wr) != r_rd))
        else $error("write into a full FIFO");

    a_second_read_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HI) |-> $past(r_state == ST_LO))
        else $error("high byte read without a low byte");

endmodule

@@ hw/rtl/byte_fifo_sample_packer_unit.sv @@
// Byte FIFO with 16-bit sample packing.
// Input channel i_in carries a command and a data byte. A push command stores
// the byte unless the FIFO already holds FIFO_DEPTH-1 bytes; a pop command
// removes up to two bytes and packs them low byte first into a signed sample,
// with missing bytes reading as zero.
// Output channel o_out returns one item per input item: write_accepted,
// sample, bytes_taken and the number of bytes left queued afterwards.
// From acceptance at the back end, a push or a pop of an empty FIFO goes
// straight to the output register; a pop of one byte passes through ST_LO,
// of two bytes through ST_LO and ST_HI, reading each byte through the
// registered read port of the store. A two-entry command queue sits in front,
// so the input keeps taking items while the back end works or waits. The back
// end takes one push per cycle while o_out.ready is high, and none mid-pop.
// Reset empties the FIFO and the command queue; the byte store itself is not
// cleared. When the receiver holds ready low the result stays in the output
// register, the back end stops, and the input stalls once the queue is full.
module byte_fifo_sample_packer_unit import bfsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfsp_in_if.sink    i_in,
    bfsp_out_if.source o_out
);

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;

    bfsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    bfsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_out       (o_out)
    );

endmodule
